/* src/ffre_pkg.sv */
// shared types and constants for the frame flip / rotate engine
// no dependencies
`timescale 1ns / 1ps

package ffre_pkg;

  localparam int CFG_DIM_W  = 9;
  localparam int CFG_MODE_W = 3;
  localparam int CFG_DATA_W = 9;
  localparam int CFG_IDX_W  = 2;

  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TRANSFORM_MODE = 2'd2;

  localparam logic [CFG_DIM_W-1:0] DIM_RESET = 9'd256;

  localparam logic [CFG_MODE_W-1:0] MODE_FLIP_V  = 3'd0;
  localparam logic [CFG_MODE_W-1:0] MODE_FLIP_H  = 3'd1;
  localparam logic [CFG_MODE_W-1:0] MODE_ROT_90  = 3'd2;
  localparam logic [CFG_MODE_W-1:0] MODE_ROT_180 = 3'd3;
  localparam logic [CFG_MODE_W-1:0] MODE_ROT_270 = 3'd4;

  localparam logic KIND_LOAD  = 1'b0;
  localparam logic KIND_FETCH = 1'b1;

  typedef struct packed {
    logic       kind;
    logic [7:0] red_in;
    logic [7:0] green_in;
    logic [7:0] blue_in;
  } in_item_t;

  typedef struct packed {
    logic [7:0] red_out;
    logic [7:0] green_out;
    logic [7:0] blue_out;
    logic [7:0] out_col;
    logic [7:0] out_row;
    logic       frame_last;
    logic       status;
  } out_item_t;

  typedef struct packed {
    logic load;
    logic fetch;
    logic read;
    logic emit;
  } ctrl_cmd_t;

endpackage

/* src/frame_flip_rotate_engine.sv */
// frame flip / rotate engine: a load is taken while idle and gives no result; a fetch
// is accepted while idle, its store address registered, the store read into a register
// and the result registered and strobed on done, with busy high in the read and emit
// states, so no new request is accepted until the fetch in flight has been emitted.
// synchronous reset clears counters and control and loads the register defaults;
// frame store contents are undefined until loaded. results cannot be stalled.
// depends on ffre_pkg, ffre_ctrl, ffre_datapath
`timescale 1ns / 1ps

module frame_flip_rotate_engine
  import ffre_pkg::*;
#(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  in_item_t              request,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output logic                  done,
  output out_item_t             result
);

  ctrl_cmd_t cmd;

  ffre_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .kind  (request.kind),
    .busy  (busy),
    .cmd   (cmd)
  );

  ffre_datapath #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .item      (request),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .done      (done),
    .result    (result)
  );

endmodule

/* src/ffre_ctrl.sv */
// controller state machine: sequences load, fetch, store read and result strobe
// depends on ffre_pkg
`timescale 1ns / 1ps

module ffre_ctrl
  import ffre_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      start,
  input  logic      kind,
  output logic      busy,
  output ctrl_cmd_t cmd
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_EMIT
  } state_t;

  state_t state;

  assign busy = (state != ST_IDLE);

  always_comb begin
    cmd       = '0;
    cmd.load  = (state == ST_IDLE) && start && (kind == KIND_LOAD);
    cmd.fetch = (state == ST_IDLE) && start && (kind == KIND_FETCH);
    cmd.read  = (state == ST_READ);
    cmd.emit  = (state == ST_EMIT);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (start && (kind == KIND_FETCH)) state <= ST_READ;
        end
        ST_READ: state <= ST_EMIT;
        ST_EMIT: state <= ST_IDLE;
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

/* src/ffre_datapath.sv */
// datapath: configuration registers, frame store, output coordinate counters,
// source address generation and result register; depends on ffre_pkg
`timescale 1ns / 1ps

module ffre_datapath
  import ffre_pkg::*;
#(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256
) (
  input  logic                  clk,
  input  logic                  rst,
  input  ctrl_cmd_t             cmd,
  input  in_item_t              item,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output logic                  done,
  output out_item_t             result
);

  localparam int MAXD  = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;
  localparam int DW    = $clog2(MAXD + 1);
  localparam int CW    = $clog2(MAXD);
  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = $clog2(DEPTH);
  localparam int TW    = $clog2(DEPTH + 1);
  localparam int PW    = 2 * DW;

  function automatic logic [DW-1:0] clamp_dim(input logic [CFG_DIM_W-1:0] v,
                                              input int maxv);
    logic [31:0] wide;
    wide = {{(32-CFG_DIM_W){1'b0}}, v};
    if (v == '0) return DW'(1);
    else if (wide > 32'(maxv)) return DW'(maxv);
    else return wide[DW-1:0];
  endfunction

  logic [23:0] store [DEPTH];

  logic [DW-1:0]         w;
  logic [DW-1:0]         h;
  logic [CFG_MODE_W-1:0] mode;
  logic [TW-1:0]         load_cnt;
  logic                  frame_ready;
  logic [CW-1:0]         oc;
  logic [CW-1:0]         orow;

  logic [AW-1:0]  rd_addr;
  logic [CW-1:0]  res_col;
  logic [CW-1:0]  res_row;
  logic           res_last;
  logic           res_bad;
  logic [23:0]    pix;

  logic [PW-1:0]  total_full;
  logic [TW-1:0]  total;
  logic [TW-1:0]  wr_ptr;
  logic [TW-1:0]  load_cnt_next;
  logic           wr_ok;
  logic [DW-1:0]  ow;
  logic [DW-1:0]  oh;
  logic           col_end;
  logic           row_end;
  logic [CW-1:0]  sx;
  logic [CW-1:0]  sy;
  logic [PW-1:0]  src_full;

  assign total_full    = PW'(w) * PW'(h);
  assign total         = total_full[TW-1:0];
  assign wr_ptr        = frame_ready ? '0 : load_cnt;
  assign wr_ok         = (wr_ptr < total);
  assign load_cnt_next = wr_ok ? (wr_ptr + TW'(1)) : wr_ptr;

  // the 90 and 270 degree rotations swap the output dimensions
  assign ow = ((mode == MODE_ROT_90) || (mode == MODE_ROT_270)) ? h : w;
  assign oh = ((mode == MODE_ROT_90) || (mode == MODE_ROT_270)) ? w : h;
  assign col_end = (DW'(oc) == (ow - DW'(1)));
  assign row_end = (DW'(orow) == (oh - DW'(1)));

  always_comb begin
    unique case (mode)
      MODE_FLIP_V: begin
        sx = oc;
        sy = CW'(h - DW'(1) - DW'(orow));
      end
      MODE_FLIP_H: begin
        sx = CW'(w - DW'(1) - DW'(oc));
        sy = orow;
      end
      MODE_ROT_90: begin
        sx = orow;
        sy = CW'(h - DW'(1) - DW'(oc));
      end
      MODE_ROT_180: begin
        sx = CW'(w - DW'(1) - DW'(oc));
        sy = CW'(h - DW'(1) - DW'(orow));
      end
      MODE_ROT_270: begin
        sx = CW'(w - DW'(1) - DW'(orow));
        sy = oc;
      end
      default: begin
        sx = oc;
        sy = orow;
      end
    endcase
  end

  assign src_full = PW'(sy) * PW'(w) + PW'(sx);

  // frame store: one write port for loads, one registered read port
  always_ff @(posedge clk) begin
    if (cmd.load && wr_ok) begin
      store[wr_ptr[AW-1:0]] <= {item.red_in, item.green_in, item.blue_in};
    end
    if (cmd.read) begin
      pix <= store[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      w           <= clamp_dim(DIM_RESET, MAX_WIDTH);
      h           <= clamp_dim(DIM_RESET, MAX_HEIGHT);
      mode        <= MODE_FLIP_V;
      load_cnt    <= '0;
      frame_ready <= 1'b0;
      oc          <= '0;
      orow        <= '0;
      done        <= 1'b0;
    end else begin
      done <= cmd.emit;
      if (cfg_we) begin
        unique case (cfg_index)
          REG_FRAME_WIDTH: begin
            w           <= clamp_dim(cfg_data, MAX_WIDTH);
            load_cnt    <= '0;
            frame_ready <= 1'b0;
            oc          <= '0;
            orow        <= '0;
          end
          REG_FRAME_HEIGHT: begin
            h           <= clamp_dim(cfg_data, MAX_HEIGHT);
            load_cnt    <= '0;
            frame_ready <= 1'b0;
            oc          <= '0;
            orow        <= '0;
          end
          REG_TRANSFORM_MODE: begin
            mode <= cfg_data[CFG_MODE_W-1:0];
            oc   <= '0;
            orow <= '0;
          end
          default: ;
        endcase
      end else if (cmd.load) begin
        // a load after a complete frame starts a new one
        load_cnt    <= load_cnt_next;
        frame_ready <= (load_cnt_next >= total);
        if (frame_ready) begin
          oc   <= '0;
          orow <= '0;
        end
      end else if (cmd.fetch && frame_ready) begin
        if (col_end && row_end) begin
          oc   <= '0;
          orow <= '0;
        end else if (col_end) begin
          oc   <= '0;
          orow <= orow + CW'(1);
        end else begin
          oc <= oc + CW'(1);
        end
      end
    end
  end

  // payload registers of the fetch in flight and the result register
  always_ff @(posedge clk) begin
    if (cmd.fetch) begin
      res_bad  <= !frame_ready;
      rd_addr  <= src_full[AW-1:0];
      res_col  <= oc;
      res_row  <= orow;
      res_last <= col_end && row_end;
    end
    if (cmd.emit) begin
      if (res_bad) begin
        result.red_out    <= '0;
        result.green_out  <= '0;
        result.blue_out   <= '0;
        result.out_col    <= '0;
        result.out_row    <= '0;
        result.frame_last <= 1'b0;
        result.status     <= 1'b1;
      end else begin
        result.red_out    <= pix[23:16];
        result.green_out  <= pix[15:8];
        result.blue_out   <= pix[7:0];
        result.out_col    <= 8'(res_col);
        result.out_row    <= 8'(res_row);
        result.frame_last <= res_last;
        result.status     <= 1'b0;
      end
    end
  end

endmodule
